// ===== rtl/laser_incidence_angle_assert.svh =====
// ----------------------------------------------------------------------------
// laser_incidence_angle_assert : assertion macros
// Clocked concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LASER_INCIDENCE_ANGLE_ASSERT_SVH
`define LASER_INCIDENCE_ANGLE_ASSERT_SVH
`ifndef SYNTH
// checked only out of reset
`define LIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// checked at every edge, reset included
`define LIA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LIA_ASSERT(lbl, prop)
`define LIA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/lia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_pkg : shared types and constants
// Widths, queue entry layout and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lia_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

  localparam int SUM_W  = 64;
  localparam int DOT_W  = 48;
  localparam int LEN_W  = 32;
  localparam int NUM_W  = 50;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam int SQ_STEPS     = 32;
  localparam int DIV_BITS     = 16;
  localparam int ASQ_STEPS    = 17;
  localparam int ASQ_W        = 34;
  localparam int CORDIC_STEPS = 17;
  localparam int X_W          = 20;
  localparam int Z_W          = 24;

  localparam int BACK_STAGES = (SQ_STEPS + 1) + (DIV_BITS + 1) + 2 +
                               (ASQ_STEPS + 1) + (CORDIC_STEPS + 1) + 1;

  localparam logic [15:0] COS_CLAMP = 16'd65529;
  localparam logic [14:0] ANGLE_MAX = 15'd23040;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DOT_W-1:0] dot_abs;
    logic             degen;
  } lia_item_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 24'sd2949120;
      5'd1:  r = 24'sd1740967;
      5'd2:  r = 24'sd919879;
      5'd3:  r = 24'sd466945;
      5'd4:  r = 24'sd234379;
      5'd5:  r = 24'sd117304;
      5'd6:  r = 24'sd58666;
      5'd7:  r = 24'sd29335;
      5'd8:  r = 24'sd14668;
      5'd9:  r = 24'sd7334;
      5'd10: r = 24'sd3667;
      5'd11: r = 24'sd1833;
      5'd12: r = 24'sd917;
      5'd13: r = 24'sd458;
      5'd14: r = 24'sd229;
      5'd15: r = 24'sd115;
      5'd16: r = 24'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lia_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_front : ray and dot product front end
// Forms the origin-to-point ray, scales it, and computes the squared
// length and the absolute dot product with the normal.
// ----------------------------------------------------------------------------
module lia_front import lia_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic               q_full,
  output logic               q_push,
  output lia_item_t          q_item
);

  logic signed [31:0] pt [3];
  logic signed [31:0] og [3];
  logic signed [15:0] nm [3];

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [32:0] d1_r  [3];
  logic signed [15:0] n1_r  [3];
  logic        [30:0] m2_r  [3];
  logic               ng2_r [3];
  logic signed [15:0] n2_r  [3];
  logic               dg2_r, dg3_r;
  logic        [61:0] sq3_r [3];
  logic signed [47:0] pr3_r [3];
  lia_item_t          item4_r;

  logic        [31:0] mag   [3];
  logic signed [32:0] negd  [3];
  logic               big;
  logic signed [31:0] vs    [3];
  logic signed [49:0] dot;
  logic signed [49:0] dot_neg;
  logic               en;

  assign pt = '{point_x, point_y, point_z};
  assign og = '{origin_x, origin_y, origin_z};
  assign nm = '{normal_x, normal_y, normal_z};

  assign en       = !(v4_r && q_full);
  assign in_stall = !en;
  assign q_push   = v4_r && !q_full;
  assign q_item   = item4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      negd[i] = -d1_r[i];
      mag[i]  = d1_r[i][32] ? negd[i][31:0] : d1_r[i][31:0];
    end
    big = mag[0][31] | mag[1][31] | mag[2][31];
    for (int i = 0; i < 3; i++) begin
      vs[i] = ng2_r[i] ? -$signed({1'b0, m2_r[i]}) : $signed({1'b0, m2_r[i]});
    end
    dot     = 50'(pr3_r[0]) + 50'(pr3_r[1]) + 50'(pr3_r[2]);
    dot_neg = -dot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= $signed({pt[i][31], pt[i]}) - $signed({og[i][31], og[i]});
        n1_r[i]  <= nm[i];
        // magnitude below 2^32, so one right shift always suffices
        m2_r[i]  <= big ? mag[i][31:1] : mag[i][30:0];
        ng2_r[i] <= d1_r[i][32];
        n2_r[i]  <= n1_r[i];
        sq3_r[i] <= 62'(m2_r[i]) * 62'(m2_r[i]);
        pr3_r[i] <= 48'(n2_r[i]) * 48'(vs[i]);
      end
      dg2_r           <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
      dg3_r           <= dg2_r;
      item4_r.sum     <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]);
      item4_r.dot_abs <= dot[49] ? dot_neg[DOT_W-1:0] : dot[DOT_W-1:0];
      item4_r.degen   <= dg3_r;
    end
  end

endmodule

// ===== rtl/lia_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_queue : decoupling queue
// Short register FIFO between the front end and the back end pipeline.
// ----------------------------------------------------------------------------
module lia_queue import lia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lia_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output lia_item_t head
);

  lia_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

// ===== rtl/lia_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_back : length, cosine and angle pipeline
// Pipelined square root, divider, clamp, second square root and CORDIC.
// ----------------------------------------------------------------------------
module lia_back import lia_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  lia_item_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cos_incidence,
  output logic [14:0] out_angle_degrees,
  output logic        out_degenerate
);

  logic                   en;
  logic [BACK_STAGES-1:0] v_r;

  // length square root
  logic [SUM_W-1:0] a_rem_r  [SQ_STEPS+1];
  logic [SUM_W-1:0] a_root_r [SQ_STEPS+1];
  logic [DOT_W-1:0] a_dot_r  [SQ_STEPS+1];
  logic             a_dg_r   [SQ_STEPS+1];
  logic [SUM_W-1:0] a_rem_nxt  [SQ_STEPS];
  logic [SUM_W-1:0] a_root_nxt [SQ_STEPS];

  // divider
  logic [NUM_W-1:0] c_rem_r [DIV_BITS+1];
  logic [15:0]      c_q_r   [DIV_BITS+1];
  logic [LEN_W-1:0] c_len_r [DIV_BITS+1];
  logic             c_ovf_r [DIV_BITS+1];
  logic             c_dg_r  [DIV_BITS+1];
  logic [NUM_W-1:0] c_rem_nxt [DIV_BITS];
  logic [15:0]      c_q_nxt   [DIV_BITS];
  logic [LEN_W-1:0] len;
  logic [NUM_W-1:0] num;

  logic [15:0] e_c_r, f_c_r;
  logic        e_dg_r, f_dg_r;
  logic [32:0] f_t_r;

  // sine square root
  logic [ASQ_W-1:0] g_rem_r  [ASQ_STEPS+1];
  logic [ASQ_W-1:0] g_root_r [ASQ_STEPS+1];
  logic [15:0]      g_c_r    [ASQ_STEPS+1];
  logic             g_dg_r   [ASQ_STEPS+1];
  logic [ASQ_W-1:0] g_rem_nxt  [ASQ_STEPS];
  logic [ASQ_W-1:0] g_root_nxt [ASQ_STEPS];

  // CORDIC vectoring
  logic signed [X_W-1:0] h_x_r  [CORDIC_STEPS+1];
  logic signed [X_W-1:0] h_y_r  [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] h_z_r  [CORDIC_STEPS+1];
  logic [15:0]           h_c_r  [CORDIC_STEPS+1];
  logic                  h_dg_r [CORDIC_STEPS+1];
  logic signed [X_W-1:0] h_x_nxt [CORDIC_STEPS];
  logic signed [X_W-1:0] h_y_nxt [CORDIC_STEPS];
  logic signed [Z_W-1:0] h_z_nxt [CORDIC_STEPS];

  logic signed [Z_W-1:0] zp, zs;
  logic [15:0]           ang16;
  logic [14:0]           ang;

  logic [15:0] cos_r;
  logic [14:0] ang_r;
  logic        dg_r;

  assign en                = !v_r[BACK_STAGES-1] || !out_stall;
  assign q_pop             = en && !q_empty;
  assign out_valid         = v_r[BACK_STAGES-1];
  assign out_cos_incidence = cos_r;
  assign out_angle_degrees = ang_r;
  assign out_degenerate    = dg_r;

  assign len = a_root_r[SQ_STEPS][LEN_W-1:0];
  assign num = 50'({a_dot_r[SQ_STEPS], 2'b00}) + 50'(len >> 1);

  always_comb begin
    logic [SUM_W-1:0] b, t;
    logic [ASQ_W-1:0] gb, gt;
    logic [NUM_W-1:0] dv;
    for (int k = 0; k < SQ_STEPS; k++) begin
      b = SUM_W'(1) << (62 - 2 * k);
      t = a_root_r[k] + b;
      if (a_rem_r[k] >= t) begin
        a_rem_nxt[k]  = a_rem_r[k] - t;
        a_root_nxt[k] = (a_root_r[k] >> 1) + b;
      end else begin
        a_rem_nxt[k]  = a_rem_r[k];
        a_root_nxt[k] = a_root_r[k] >> 1;
      end
    end
    for (int j = 0; j < DIV_BITS; j++) begin
      dv = NUM_W'(c_len_r[j]) << (DIV_BITS - 1 - j);
      c_q_nxt[j] = c_q_r[j];
      if (c_rem_r[j] >= dv) begin
        c_rem_nxt[j] = c_rem_r[j] - dv;
        c_q_nxt[j][DIV_BITS-1-j] = 1'b1;
      end else begin
        c_rem_nxt[j] = c_rem_r[j];
      end
    end
    for (int k = 0; k < ASQ_STEPS; k++) begin
      gb = ASQ_W'(1) << (32 - 2 * k);
      gt = g_root_r[k] + gb;
      if (g_rem_r[k] >= gt) begin
        g_rem_nxt[k]  = g_rem_r[k] - gt;
        g_root_nxt[k] = (g_root_r[k] >> 1) + gb;
      end else begin
        g_rem_nxt[k]  = g_rem_r[k];
        g_root_nxt[k] = g_root_r[k] >> 1;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (h_y_r[i] > 0) begin
        h_x_nxt[i] = h_x_r[i] + (h_y_r[i] >>> i);
        h_y_nxt[i] = h_y_r[i] - (h_x_r[i] >>> i);
        h_z_nxt[i] = h_z_r[i] + atan_lut(5'(i));
      end else begin
        h_x_nxt[i] = h_x_r[i] - (h_y_r[i] >>> i);
        h_y_nxt[i] = h_y_r[i] + (h_x_r[i] >>> i);
        h_z_nxt[i] = h_z_r[i] - atan_lut(5'(i));
      end
    end
    zp    = h_z_r[CORDIC_STEPS][Z_W-1] ? '0 : h_z_r[CORDIC_STEPS];
    zs    = zp + Z_W'(128);
    ang16 = zs[Z_W-1:8];
    ang   = (ang16 > 16'(ANGLE_MAX)) ? ANGLE_MAX : ang16[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[BACK_STAGES-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rem_r[0]  <= q_head.sum;
      a_root_r[0] <= '0;
      a_dot_r[0]  <= q_head.dot_abs;
      a_dg_r[0]   <= q_head.degen;
      for (int k = 0; k < SQ_STEPS; k++) begin
        a_rem_r[k+1]  <= a_rem_nxt[k];
        a_root_r[k+1] <= a_root_nxt[k];
        a_dot_r[k+1]  <= a_dot_r[k];
        a_dg_r[k+1]   <= a_dg_r[k];
      end

      c_rem_r[0] <= num;
      c_q_r[0]   <= '0;
      c_len_r[0] <= len;
      c_ovf_r[0] <= num >= NUM_W'({len, 16'h0000});
      c_dg_r[0]  <= a_dg_r[SQ_STEPS];
      for (int j = 0; j < DIV_BITS; j++) begin
        c_rem_r[j+1] <= c_rem_nxt[j];
        c_q_r[j+1]   <= c_q_nxt[j];
        c_len_r[j+1] <= c_len_r[j];
        c_ovf_r[j+1] <= c_ovf_r[j];
        c_dg_r[j+1]  <= c_dg_r[j];
      end

      e_c_r  <= (c_ovf_r[DIV_BITS] || c_q_r[DIV_BITS] > COS_CLAMP) ?
                COS_CLAMP : c_q_r[DIV_BITS];
      e_dg_r <= c_dg_r[DIV_BITS];
      f_t_r  <= 33'h1_0000_0000 - 33'(32'(e_c_r) * 32'(e_c_r));
      f_c_r  <= e_c_r;
      f_dg_r <= e_dg_r;

      g_rem_r[0]  <= ASQ_W'(f_t_r);
      g_root_r[0] <= '0;
      g_c_r[0]    <= f_c_r;
      g_dg_r[0]   <= f_dg_r;
      for (int k = 0; k < ASQ_STEPS; k++) begin
        g_rem_r[k+1]  <= g_rem_nxt[k];
        g_root_r[k+1] <= g_root_nxt[k];
        g_c_r[k+1]    <= g_c_r[k];
        g_dg_r[k+1]   <= g_dg_r[k];
      end

      h_x_r[0]  <= $signed({4'b0000, g_c_r[ASQ_STEPS]});
      h_y_r[0]  <= $signed({3'b000, g_root_r[ASQ_STEPS][16:0]});
      h_z_r[0]  <= '0;
      h_c_r[0]  <= g_c_r[ASQ_STEPS];
      h_dg_r[0] <= g_dg_r[ASQ_STEPS];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        h_x_r[i+1]  <= h_x_nxt[i];
        h_y_r[i+1]  <= h_y_nxt[i];
        h_z_r[i+1]  <= h_z_nxt[i];
        h_c_r[i+1]  <= h_c_r[i];
        h_dg_r[i+1] <= h_dg_r[i];
      end

      cos_r <= h_dg_r[CORDIC_STEPS] ? '0 : h_c_r[CORDIC_STEPS];
      ang_r <= h_dg_r[CORDIC_STEPS] ? '0 : ang;
      dg_r  <= h_dg_r[CORDIC_STEPS];
    end
  end

endmodule

// ===== rtl/laser_incidence_angle.sv =====
`timescale 1ns / 1ps
// Path: from transaction accept to result valid through 4 front stages, the
//   queue register and 89 back stages incl. output register.
// Throughput: one transaction per cycle while out_stall is low; set by the fully
//   pipelined square roots (one root bit per stage), divider and CORDIC.
// Reset: synchronous active-low rst_n clears the origin registers to 0,
//   all stage valid bits and the queue; no result is pending after reset.
// ----------------------------------------------------------------------------
// laser_incidence_angle : incidence cosine and angle of a laser return
// Front end forms ray and dot product, a short queue decouples it from the
// back end that computes |cos| (Q0.16, clamped) and acos in 1/256 degree.
// ----------------------------------------------------------------------------
`include "laser_incidence_angle_assert.svh"

module laser_incidence_angle import lia_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  input  logic signed [15:0]   in_normal_x,
  input  logic signed [15:0]   in_normal_y,
  input  logic signed [15:0]   in_normal_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_cos_incidence,
  output logic [14:0]          out_angle_degrees,
  output logic                 out_degenerate
);

  // sensor origin, Q16.16; the user must see that it is written only while idle, which the block leaves unchecked
  logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;

  logic      q_push, q_full, q_pop, q_empty;
  lia_item_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_ORIGIN_Z: origin_z_r <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front end: ray, scaling, squared length and |dot|
  lia_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .normal_x (in_normal_x),
    .normal_y (in_normal_y),
    .normal_z (in_normal_z),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .origin_z (origin_z_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // queue lets front and back stall independently
  lia_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back end: length, rounded divide, clamp, acos via sqrt + CORDIC
  lia_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cos_incidence (out_cos_incidence),
    .out_angle_degrees (out_angle_degrees),
    .out_degenerate    (out_degenerate)
  );

  `LIA_ASSERT(a_degen_zero, out_valid && out_degenerate |-> out_cos_incidence == '0 && out_angle_degrees == '0)
  `LIA_ASSERT(a_cos_range, out_valid |-> out_cos_incidence <= COS_CLAMP)
  `LIA_ASSERT(a_angle_range, out_valid |-> out_angle_degrees <= ANGLE_MAX)
  `LIA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !q_pop)

endmodule
